// File: design/qvr_pkg.sv
// shared constants, types and register codes of the quaternion vector rotator
package qvr_pkg;

    localparam int VEC_WIDTH     = 32;
    localparam int QUAT_WIDTH    = 16;
    localparam int QFRAC         = QUAT_WIDTH - 2;
    localparam int MSHIFT        = 2 * QFRAC;
    localparam int QPROD_WIDTH   = 2 * QUAT_WIDTH;
    localparam int MAT_WIDTH     = 2 * QUAT_WIDTH + 2;
    localparam int VLO_WIDTH     = VEC_WIDTH / 2;
    localparam int VHI_WIDTH     = VEC_WIDTH - VLO_WIDTH;
    localparam int PLO_WIDTH     = MAT_WIDTH + VLO_WIDTH + 1;
    localparam int PHI_WIDTH     = MAT_WIDTH + VHI_WIDTH;
    localparam int PROD_WIDTH    = MAT_WIDTH + VEC_WIDTH;
    localparam int ACC_WIDTH     = PROD_WIDTH + 2;
    localparam int RND_WIDTH     = ACC_WIDTH - MSHIFT;
    localparam int CFG_IDX_WIDTH = 2;

    typedef logic signed [VEC_WIDTH-1:0]   vec_t;
    typedef logic signed [QUAT_WIDTH-1:0]  quat_t;
    typedef logic signed [QPROD_WIDTH-1:0] qprod_t;
    typedef logic signed [MAT_WIDTH-1:0]   mat_elem_t;
    typedef logic signed [ACC_WIDTH-1:0]   acc_t;

    typedef enum logic [CFG_IDX_WIDTH-1:0] {
        CFG_QUAT_W = 2'd0,
        CFG_QUAT_X = 2'd1,
        CFG_QUAT_Y = 2'd2,
        CFG_QUAT_Z = 2'd3
    } cfg_idx_t;

    // 1.0 in the quaternion format and in the matrix format
    localparam quat_t     QUAT_ONE = {2'b01, {QFRAC{1'b0}}};
    localparam mat_elem_t MAT_ONE  = {{(MAT_WIDTH-MSHIFT-1){1'b0}}, 1'b1, {MSHIFT{1'b0}}};

    // half an output lsb, added before the final shift
    localparam acc_t ACC_HALF = {{(ACC_WIDTH-MSHIFT){1'b0}}, 1'b1, {(MSHIFT-1){1'b0}}};

    localparam vec_t VEC_MAX = {1'b0, {(VEC_WIDTH-1){1'b1}}};
    localparam vec_t VEC_MIN = {1'b1, {(VEC_WIDTH-1){1'b0}}};

endpackage

// File: design/qvr_matrix.sv
// quaternion registers, quaternion product registers and rotation matrix forming
module qvr_matrix (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_wr_en,
    input  logic [qvr_pkg::CFG_IDX_WIDTH-1:0]    cfg_wr_idx,
    input  logic [qvr_pkg::QUAT_WIDTH-1:0]       cfg_wr_data,
    output qvr_pkg::mat_elem_t                   mat [3][3]
);

    qvr_pkg::quat_t  qw_reg, qx_reg, qy_reg, qz_reg;
    qvr_pkg::quat_t  qw_next, qx_next, qy_next, qz_next;
    qvr_pkg::qprod_t xx_reg, yy_reg, zz_reg, xy_reg, xz_reg, yz_reg, xw_reg, yw_reg, zw_reg;
    qvr_pkg::cfg_idx_t idx;

    // twice the sum or difference of two products, in matrix width
    function automatic qvr_pkg::mat_elem_t dbl(input qvr_pkg::qprod_t a,
                                               input qvr_pkg::qprod_t b,
                                               input logic sub);
        qvr_pkg::mat_elem_t ea, eb, s;
        ea = {{(qvr_pkg::MAT_WIDTH-qvr_pkg::QPROD_WIDTH){a[qvr_pkg::QPROD_WIDTH-1]}}, a};
        eb = {{(qvr_pkg::MAT_WIDTH-qvr_pkg::QPROD_WIDTH){b[qvr_pkg::QPROD_WIDTH-1]}}, b};
        s  = sub ? ea - eb : ea + eb;
        return {s[qvr_pkg::MAT_WIDTH-2:0], 1'b0};
    endfunction

    assign idx = qvr_pkg::cfg_idx_t'(cfg_wr_idx);

    always_comb begin
        qw_next = qw_reg;
        qx_next = qx_reg;
        qy_next = qy_reg;
        qz_next = qz_reg;
        if (cfg_wr_en) begin
            unique case (idx)
                qvr_pkg::CFG_QUAT_W: qw_next = cfg_wr_data;
                qvr_pkg::CFG_QUAT_X: qx_next = cfg_wr_data;
                qvr_pkg::CFG_QUAT_Y: qy_next = cfg_wr_data;
                qvr_pkg::CFG_QUAT_Z: qz_next = cfg_wr_data;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            qw_reg <= qvr_pkg::QUAT_ONE;
            qx_reg <= '0;
            qy_reg <= '0;
            qz_reg <= '0;
        end else begin
            qw_reg <= qw_next;
            qx_reg <= qx_next;
            qy_reg <= qy_next;
            qz_reg <= qz_next;
        end
    end

    // products follow the registers in the next cycle
    always_ff @(posedge aclk) begin
        xx_reg <= qx_reg * qx_reg;
        yy_reg <= qy_reg * qy_reg;
        zz_reg <= qz_reg * qz_reg;
        xy_reg <= qx_reg * qy_reg;
        xz_reg <= qx_reg * qz_reg;
        yz_reg <= qy_reg * qz_reg;
        xw_reg <= qx_reg * qw_reg;
        yw_reg <= qy_reg * qw_reg;
        zw_reg <= qz_reg * qw_reg;
    end

    always_comb begin
        mat[0][0] = qvr_pkg::MAT_ONE - dbl(yy_reg, zz_reg, 1'b0);
        mat[0][1] = dbl(xy_reg, zw_reg, 1'b1);
        mat[0][2] = dbl(xz_reg, yw_reg, 1'b0);
        mat[1][0] = dbl(xy_reg, zw_reg, 1'b0);
        mat[1][1] = qvr_pkg::MAT_ONE - dbl(xx_reg, zz_reg, 1'b0);
        mat[1][2] = dbl(yz_reg, xw_reg, 1'b1);
        mat[2][0] = dbl(xz_reg, yw_reg, 1'b1);
        mat[2][1] = dbl(yz_reg, xw_reg, 1'b0);
        mat[2][2] = qvr_pkg::MAT_ONE - dbl(xx_reg, yy_reg, 1'b0);
    end

endmodule

// File: design/qvr_front.sv
// input register stage and matrix / transpose element select stage
module qvr_front (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic                 s_func,
    input  qvr_pkg::vec_t        s_vec [3],
    input  qvr_pkg::mat_elem_t   mat [3][3],
    output logic                 sel_valid,
    input  logic                 sel_ready,
    output qvr_pkg::mat_elem_t   sel_elem [3][3],
    output qvr_pkg::vec_t        sel_vec [3]
);

    logic               in_v_reg, sel_v_reg;
    logic               in_v_next, sel_v_next;
    logic               in_en, sel_en;
    logic               func_reg;
    qvr_pkg::vec_t      vec_reg [3];
    qvr_pkg::vec_t      svec_reg [3];
    qvr_pkg::mat_elem_t elem_reg [3][3];
    qvr_pkg::mat_elem_t elem_next [3][3];

    // a stage moves when it is empty or its successor moves
    assign sel_en  = !sel_v_reg || sel_ready;
    assign in_en   = !in_v_reg || sel_en;
    assign s_ready = in_en;

    assign in_v_next  = in_en ? s_valid : in_v_reg;
    assign sel_v_next = sel_en ? in_v_reg : sel_v_reg;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                elem_next[i][j] = func_reg ? mat[j][i] : mat[i][j];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_v_reg  <= 1'b0;
            sel_v_reg <= 1'b0;
        end else begin
            in_v_reg  <= in_v_next;
            sel_v_reg <= sel_v_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_en) begin
            func_reg <= s_func;
            for (int i = 0; i < 3; i++) vec_reg[i] <= s_vec[i];
        end
        if (sel_en) begin
            for (int i = 0; i < 3; i++) begin
                svec_reg[i] <= vec_reg[i];
                for (int j = 0; j < 3; j++) elem_reg[i][j] <= elem_next[i][j];
            end
        end
    end

    assign sel_valid = sel_v_reg;
    assign sel_vec   = svec_reg;
    assign sel_elem  = elem_reg;

endmodule

// File: design/qvr_mac.sv
// split multiply, partial product merge and row accumulate stages
module qvr_mac (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 sel_valid,
    output logic                 sel_ready,
    input  qvr_pkg::mat_elem_t   sel_elem [3][3],
    input  qvr_pkg::vec_t        sel_vec [3],
    output logic                 acc_valid,
    input  logic                 acc_ready,
    output qvr_pkg::acc_t        acc [3]
);

    typedef logic signed [qvr_pkg::PLO_WIDTH-1:0]  plo_t;
    typedef logic signed [qvr_pkg::PHI_WIDTH-1:0]  phi_t;
    typedef logic signed [qvr_pkg::PROD_WIDTH-1:0] prod_t;

    logic          mul_v_reg, term_v_reg, acc_v_reg;
    logic          mul_en, term_en, acc_en;
    plo_t          plo_reg [3][3];
    phi_t          phi_reg [3][3];
    plo_t          plo_next [3][3];
    phi_t          phi_next [3][3];
    prod_t         term_reg [3][3];
    prod_t         term_next [3][3];
    qvr_pkg::acc_t acc_reg [3];
    qvr_pkg::acc_t acc_next [3];

    assign acc_en    = !acc_v_reg || acc_ready;
    assign term_en   = !term_v_reg || acc_en;
    assign mul_en    = !mul_v_reg || term_en;
    assign sel_ready = mul_en;

    // each vector component split into an unsigned low half and a signed high half
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                plo_next[i][j] = sel_elem[i][j]
                               * $signed({1'b0, sel_vec[j][qvr_pkg::VLO_WIDTH-1:0]});
                phi_next[i][j] = sel_elem[i][j]
                               * $signed(sel_vec[j][qvr_pkg::VEC_WIDTH-1:qvr_pkg::VLO_WIDTH]);
            end
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                term_next[i][j] = {phi_reg[i][j], {qvr_pkg::VLO_WIDTH{1'b0}}}
                    + {{(qvr_pkg::PROD_WIDTH-qvr_pkg::PLO_WIDTH){
                         plo_reg[i][j][qvr_pkg::PLO_WIDTH-1]}}, plo_reg[i][j]};
            end
        end
    end

    // row sum with rounding half folded in
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            acc_next[i] = {{2{term_reg[i][0][qvr_pkg::PROD_WIDTH-1]}}, term_reg[i][0]}
                        + {{2{term_reg[i][1][qvr_pkg::PROD_WIDTH-1]}}, term_reg[i][1]}
                        + {{2{term_reg[i][2][qvr_pkg::PROD_WIDTH-1]}}, term_reg[i][2]}
                        + qvr_pkg::ACC_HALF;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mul_v_reg  <= 1'b0;
            term_v_reg <= 1'b0;
            acc_v_reg  <= 1'b0;
        end else begin
            if (mul_en)  mul_v_reg  <= sel_valid;
            if (term_en) term_v_reg <= mul_v_reg;
            if (acc_en)  acc_v_reg  <= term_v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (mul_en) begin
            plo_reg <= plo_next;
            phi_reg <= phi_next;
        end
        if (term_en) term_reg <= term_next;
        if (acc_en)  acc_reg  <= acc_next;
    end

    assign acc_valid = acc_v_reg;
    assign acc       = acc_reg;

endmodule

// File: design/qvr_round.sv
// final shift, saturation and output register
module qvr_round (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            acc_valid,
    output logic            acc_ready,
    input  qvr_pkg::acc_t   acc [3],
    output logic            out_valid,
    input  logic            out_ready,
    output qvr_pkg::vec_t   out_vec [3],
    output logic            out_sat
);

    logic          out_v_reg, out_en, sat_reg, sat_next;
    qvr_pkg::vec_t vec_reg [3];
    qvr_pkg::vec_t vec_next [3];
    logic [qvr_pkg::RND_WIDTH-1:0]             rnd [3];
    logic [qvr_pkg::RND_WIDTH-qvr_pkg::VEC_WIDTH:0] top_bits [3];
    logic [2:0]    ovf;

    assign out_en    = !out_v_reg || out_ready;
    assign acc_ready = out_en;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            rnd[i]      = acc[i][qvr_pkg::ACC_WIDTH-1:qvr_pkg::MSHIFT];
            top_bits[i] = rnd[i][qvr_pkg::RND_WIDTH-1:qvr_pkg::VEC_WIDTH-1];
            // in range only if all bits above the result agree with its sign
            ovf[i]      = !((&top_bits[i]) || (~|top_bits[i]));
            if (ovf[i]) begin
                vec_next[i] = rnd[i][qvr_pkg::RND_WIDTH-1] ? qvr_pkg::VEC_MIN : qvr_pkg::VEC_MAX;
            end else begin
                vec_next[i] = rnd[i][qvr_pkg::VEC_WIDTH-1:0];
            end
        end
        sat_next = |ovf;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_v_reg <= 1'b0;
        end else if (out_en) begin
            out_v_reg <= acc_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_en) begin
            vec_reg <= vec_next;
            sat_reg <= sat_next;
        end
    end

    assign out_valid = out_v_reg;
    assign out_vec   = vec_reg;
    assign out_sat   = sat_reg;

endmodule

// File: design/quaternion_vector_rotator.sv
// top level: rotates Q16.16 vectors by the matrix of a Q2.14 quaternion
// pipeline: six register stages, input, select, multiply, merge, accumulate and output
// throughput: one vector per cycle unless held, set by the fully pipelined 3x3 multiply array
// back-pressure: each stage holds when full and stalled, bubbles close up behind it
// reset: synchronous active-low aresetn empties the pipeline and loads the identity quaternion
// a quaternion write is seen by a vector transferred from the next cycle on
module quaternion_vector_rotator (
    input  logic                              aclk,
    input  logic                              aresetn,

    // quaternion register writes
    input  logic                              cfg_wr_en,
    input  logic [qvr_pkg::CFG_IDX_WIDTH-1:0] cfg_wr_idx,
    input  logic [qvr_pkg::QUAT_WIDTH-1:0]    cfg_wr_data,

    // vector input channel
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic                              s_func,
    input  qvr_pkg::vec_t                     s_vec_x,
    input  qvr_pkg::vec_t                     s_vec_y,
    input  qvr_pkg::vec_t                     s_vec_z,

    // rotated vector output channel
    output logic                              m_valid,
    input  logic                              m_ready,
    output qvr_pkg::vec_t                     m_out_x,
    output qvr_pkg::vec_t                     m_out_y,
    output qvr_pkg::vec_t                     m_out_z,
    output logic                              m_saturated
);

    // rotation matrix, recomputed from the registers every cycle
    qvr_pkg::mat_elem_t mat [3][3];

    // select stage to multiply-accumulate stages
    logic               sel_valid, sel_ready;
    qvr_pkg::mat_elem_t sel_elem [3][3];
    qvr_pkg::vec_t      sel_vec [3];

    // accumulate stage to rounding stage
    logic               acc_valid, acc_ready;
    qvr_pkg::acc_t      acc [3];

    qvr_pkg::vec_t      s_vec [3];
    qvr_pkg::vec_t      out_vec [3];

    assign s_vec[0] = s_vec_x;
    assign s_vec[1] = s_vec_y;
    assign s_vec[2] = s_vec_z;

    // quaternion registers and the nine matrix terms
    qvr_matrix u_matrix (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_idx  (cfg_wr_idx),
        .cfg_wr_data (cfg_wr_data),
        .mat         (mat)
    );

    // input register, then picks the matrix or its transpose per item
    qvr_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_func    (s_func),
        .s_vec     (s_vec),
        .mat       (mat),
        .sel_valid (sel_valid),
        .sel_ready (sel_ready),
        .sel_elem  (sel_elem),
        .sel_vec   (sel_vec)
    );

    // nine split products, merged, then summed per row with the rounding half
    qvr_mac u_mac (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .sel_valid (sel_valid),
        .sel_ready (sel_ready),
        .sel_elem  (sel_elem),
        .sel_vec   (sel_vec),
        .acc_valid (acc_valid),
        .acc_ready (acc_ready),
        .acc       (acc)
    );

    // shift down to Q16.16, clip, and hold the result for the output transfer
    qvr_round u_round (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .acc_valid (acc_valid),
        .acc_ready (acc_ready),
        .acc       (acc),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_vec   (out_vec),
        .out_sat   (m_saturated)
    );

    assign m_out_x = out_vec[0];
    assign m_out_y = out_vec[1];
    assign m_out_z = out_vec[2];

    // input stalls only when every stage down to the output is full and held
    a_stall_from_output: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (m_valid && !m_ready))
        else $error("input stalled without a held result at the output");

    // an empty output register frees the whole pipeline
    a_empty_output_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input not ready while output register is empty");

    // a clipped result carries a bound on at least one component
    a_sat_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_saturated) |->
            (m_out_x == qvr_pkg::VEC_MAX || m_out_x == qvr_pkg::VEC_MIN ||
             m_out_y == qvr_pkg::VEC_MAX || m_out_y == qvr_pkg::VEC_MIN ||
             m_out_z == qvr_pkg::VEC_MAX || m_out_z == qvr_pkg::VEC_MIN))
        else $error("saturated flag set with no component at a bound");

    // selection stage and the rest stay in step with the output side
    a_sel_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (sel_valid && !sel_ready) |-> (acc_valid && !acc_ready))
        else $error("select stage held while the accumulate stage moves");

endmodule

// File: test/rotation_checker.sv
// checker for the quaternion vector rotator: predicts each rotated vector and compares results
`timescale 1ns / 100ps

module rotation_checker
    import qvr_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     cfg_wr_en,
    input  logic [CFG_IDX_WIDTH-1:0] cfg_wr_idx,
    input  logic [QUAT_WIDTH-1:0]    cfg_wr_data,
    input  logic                     s_valid,
    input  logic                     s_ready,
    input  logic                     s_func,
    input  vec_t                     s_vec_x,
    input  vec_t                     s_vec_y,
    input  vec_t                     s_vec_z,
    input  logic                     m_valid,
    input  logic                     m_ready,
    input  vec_t                     m_out_x,
    input  vec_t                     m_out_y,
    input  vec_t                     m_out_z,
    input  logic                     m_saturated,
    output int                       fail_count,
    output int                       pending
);

    localparam int REPORT_LIMIT = 10;

    // wide enough for the exact sum of three matrix-by-vector products
    typedef logic signed [95:0] dot_t;

    typedef struct packed {
        vec_t x;
        vec_t y;
        vec_t z;
        logic sat;
    } rotated_t;

    quat_t    quat_w, quat_x, quat_y, quat_z;
    rotated_t expected_rotations [$];

    function automatic rotated_t rotate_vector(logic inv, vec_t vx, vec_t vy, vec_t vz);
        longint   m [3][3];
        longint   w, x, y, z, one;
        dot_t     v [3];
        dot_t     acc, rnd;
        vec_t     res [3];
        logic     clip;
        int       i, j;
        rotated_t r;
        w   = longint'(quat_w);
        x   = longint'(quat_x);
        y   = longint'(quat_y);
        z   = longint'(quat_z);
        one = longint'(1) << MSHIFT;
        m[0][0] = one - 2 * (y * y + z * z);
        m[0][1] = 2 * (x * y - z * w);
        m[0][2] = 2 * (x * z + y * w);
        m[1][0] = 2 * (x * y + z * w);
        m[1][1] = one - 2 * (x * x + z * z);
        m[1][2] = 2 * (y * z - x * w);
        m[2][0] = 2 * (x * z - y * w);
        m[2][1] = 2 * (y * z + x * w);
        m[2][2] = one - 2 * (x * x + y * y);
        v[0] = dot_t'(vx);
        v[1] = dot_t'(vy);
        v[2] = dot_t'(vz);
        clip = 1'b0;
        for (i = 0; i < 3; i++) begin
            acc = '0;
            for (j = 0; j < 3; j++)
                acc = acc + dot_t'(inv ? m[j][i] : m[i][j]) * v[j];
            // round half up, then clip to the vector range
            rnd = (acc + (dot_t'(1) <<< (MSHIFT - 1))) >>> MSHIFT;
            if (rnd > dot_t'(VEC_MAX)) begin
                res[i] = VEC_MAX;
                clip   = 1'b1;
            end else if (rnd < dot_t'(VEC_MIN)) begin
                res[i] = VEC_MIN;
                clip   = 1'b1;
            end else begin
                res[i] = vec_t'(rnd);
            end
        end
        r.x   = res[0];
        r.y   = res[1];
        r.z   = res[2];
        r.sat = clip;
        return r;
    endfunction

    task automatic flag_failure(string msg);
        fail_count++;
        if (fail_count <= REPORT_LIMIT)
            $display("%t: %s", $realtime, msg);
    endtask

    task automatic compare_field(string field, longint want, longint got);
        if (want != got)
            flag_failure($sformatf("%s mismatch: expected %0d, got %0d", field, want, got));
    endtask

    always @(posedge aclk) begin
        rotated_t want;
        if (!aresetn) begin
            quat_w = QUAT_ONE;
            quat_x = '0;
            quat_y = '0;
            quat_z = '0;
            expected_rotations.delete();
        end else begin
            // result side first: a transfer here can never belong to this cycle's input
            if (m_valid && m_ready) begin
                if (expected_rotations.size() == 0) begin
                    flag_failure($sformatf("unexpected result %0d %0d %0d sat %0b",
                                           m_out_x, m_out_y, m_out_z, m_saturated));
                end else begin
                    want = expected_rotations.pop_front();
                    compare_field("out_x", longint'(want.x), longint'(m_out_x));
                    compare_field("out_y", longint'(want.y), longint'(m_out_y));
                    compare_field("out_z", longint'(want.z), longint'(m_out_z));
                    compare_field("saturated", longint'(want.sat), longint'(m_saturated));
                end
            end
            if (s_valid && s_ready)
                expected_rotations.push_back(rotate_vector(s_func, s_vec_x, s_vec_y, s_vec_z));
            // a register write applies from the next transfer on
            if (cfg_wr_en) begin
                case (cfg_idx_t'(cfg_wr_idx))
                    CFG_QUAT_W: quat_w = quat_t'(cfg_wr_data);
                    CFG_QUAT_X: quat_x = quat_t'(cfg_wr_data);
                    CFG_QUAT_Y: quat_y = quat_t'(cfg_wr_data);
                    CFG_QUAT_Z: quat_z = quat_t'(cfg_wr_data);
                    default: ;
                endcase
            end
        end
        pending <= expected_rotations.size();
    end

endmodule

// File: test/tb_quaternion_vector_rotator.sv
// testbench top for the quaternion vector rotator: stimulus, flow control and verdict
`timescale 1ns / 100ps

module tb_quaternion_vector_rotator;
    import qvr_pkg::*;

    localparam int CLK_PERIOD        = 8;
    localparam int RANDOM_PHASES     = 8;
    localparam int ITEMS_PER_PHASE   = 50;
    localparam int HOLD_PHASE        = 2;
    localparam int SINK_HOLD_CYCLES  = 200;
    localparam int STALL_LIMIT       = 2000;
    localparam int DRAIN_CYCLES      = 12;

    logic                     aclk = 1'b0;
    logic                     aresetn;
    logic                     cfg_wr_en;
    logic [CFG_IDX_WIDTH-1:0] cfg_wr_idx;
    logic [QUAT_WIDTH-1:0]    cfg_wr_data;
    logic                     s_valid;
    logic                     s_ready;
    logic                     s_func;
    vec_t                     s_vec_x, s_vec_y, s_vec_z;
    logic                     m_valid;
    logic                     m_ready;
    vec_t                     m_out_x, m_out_y, m_out_z;
    logic                     m_saturated;

    int fail_count;
    int pending;

    // flow-control moods of the sender and the receiver process; quiet_tail is shared by both
    bit src_jittery;
    bit sink_jittery;
    bit quiet_tail;
    bit sink_hold_req;

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    quaternion_vector_rotator u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_idx  (cfg_wr_idx),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_func      (s_func),
        .s_vec_x     (s_vec_x),
        .s_vec_y     (s_vec_y),
        .s_vec_z     (s_vec_z),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_x     (m_out_x),
        .m_out_y     (m_out_y),
        .m_out_z     (m_out_z),
        .m_saturated (m_saturated)
    );

    rotation_checker u_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_idx  (cfg_wr_idx),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_func      (s_func),
        .s_vec_x     (s_vec_x),
        .s_vec_y     (s_vec_y),
        .s_vec_z     (s_vec_z),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_x     (m_out_x),
        .m_out_y     (m_out_y),
        .m_out_z     (m_out_z),
        .m_saturated (m_saturated),
        .fail_count  (fail_count),
        .pending     (pending)
    );

    // offer one vector and hold it until the transfer, sometimes after an idle burst
    task automatic send_vector(input logic f, input vec_t x, input vec_t y, input vec_t z);
        if (!quiet_tail && $urandom_range(0, 39) == 0)
            src_jittery = !src_jittery;
        if (src_jittery && !quiet_tail && $urandom_range(0, 5) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_func  <= f;
        s_vec_x <= x;
        s_vec_y <= y;
        s_vec_z <= z;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // stop offering and wait until every predicted result has been transferred
    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
    endtask

    // back-to-back register writes, only ever issued with the pipeline empty
    task automatic load_quaternion(input quat_t w, input quat_t x, input quat_t y,
                                   input quat_t z);
        cfg_wr_en   <= 1'b1;
        cfg_wr_idx  <= CFG_QUAT_W;
        cfg_wr_data <= w;
        @(posedge aclk);
        cfg_wr_idx  <= CFG_QUAT_X;
        cfg_wr_data <= x;
        @(posedge aclk);
        cfg_wr_idx  <= CFG_QUAT_Y;
        cfg_wr_data <= y;
        @(posedge aclk);
        cfg_wr_idx  <= CFG_QUAT_Z;
        cfg_wr_data <= z;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    function automatic quat_t quat_corner();
        case ($urandom_range(0, 6))
            0:       return quat_t'(-32768);
            1:       return quat_t'(-16384);
            2:       return quat_t'(-1);
            3:       return quat_t'(0);
            4:       return quat_t'(1);
            5:       return QUAT_ONE;
            default: return quat_t'(32767);
        endcase
    endfunction

    // mostly near-unit rotations, some raw register patterns and corner values
    task automatic pick_quaternion(output quat_t w, output quat_t x, output quat_t y,
                                   output quat_t z);
        real a [4];
        real norm;
        int  k;
        case ($urandom_range(0, 9))
            6, 7: begin
                w = quat_t'($urandom);
                x = quat_t'($urandom);
                y = quat_t'($urandom);
                z = quat_t'($urandom);
            end
            8, 9: begin
                w = quat_corner();
                x = quat_corner();
                y = quat_corner();
                z = quat_corner();
            end
            default: begin
                for (k = 0; k < 4; k++)
                    a[k] = real'($urandom_range(0, 20000)) - 10000.0;
                norm = $sqrt(a[0] * a[0] + a[1] * a[1] + a[2] * a[2] + a[3] * a[3]);
                if (norm < 1.0) begin
                    w = QUAT_ONE;
                    x = '0;
                    y = '0;
                    z = '0;
                end else begin
                    w = quat_t'($rtoi(a[0] * 16384.0 / norm));
                    x = quat_t'($rtoi(a[1] * 16384.0 / norm));
                    y = quat_t'($rtoi(a[2] * 16384.0 / norm));
                    z = quat_t'($rtoi(a[3] * 16384.0 / norm));
                end
            end
        endcase
    endtask

    // full-range words, moderate magnitudes, tiny values and the range ends
    function automatic vec_t pick_component();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: return vec_t'($urandom);
            5, 6, 7:       return vec_t'(int'($urandom_range(0, 2 ** 21)) - 2 ** 20);
            8:             return $urandom_range(0, 1) ? VEC_MAX : VEC_MIN;
            default:       return vec_t'(int'($urandom_range(0, 6)) - 3);
        endcase
    endfunction

    // receiver: random stall bursts, one long hold-off on request, none in the tail
    initial begin : result_sink
        int stall_left;
        stall_left = 0;
        m_ready    = 1'b0;
        forever begin
            @(posedge aclk);
            if (sink_hold_req) begin
                sink_hold_req = 1'b0;
                stall_left    = SINK_HOLD_CYCLES;
            end else if (!quiet_tail && $urandom_range(0, 47) == 0) begin
                sink_jittery = !sink_jittery;
            end
            if (stall_left == 0 && sink_jittery && !quiet_tail && $urandom_range(0, 5) == 0)
                stall_left = $urandom_range(1, 8);
            if (stall_left > 0) begin
                m_ready <= 1'b0;
                stall_left--;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // watchdog: too long without any transfer on either channel ends the run
    initial begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("== FAIL ==");
        $finish;
    end

    initial begin : stimulus
        quat_t qw, qx, qy, qz;
        int    phase;

        aresetn     = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_idx  = CFG_QUAT_W;
        cfg_wr_data = '0;
        s_valid     = 1'b0;
        s_func      = 1'b0;
        s_vec_x     = '0;
        s_vec_y     = '0;
        s_vec_z     = '0;
        src_jittery  = 1'b1;
        sink_jittery = 1'b1;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // identity quaternion straight from reset: range ends pass through untouched
        send_vector(1'b0, 32'sd0, 32'sd0, 32'sd0);
        send_vector(1'b0, VEC_MAX, VEC_MIN, 32'sd1);
        send_vector(1'b1, VEC_MIN, VEC_MAX, -32'sd1);
        send_vector(1'b1, VEC_MAX, VEC_MAX, VEC_MAX);
        send_vector(1'b0, VEC_MIN, VEC_MIN, VEC_MIN);
        send_vector(1'b0, 32'sh5555_5555, 32'shAAAA_AAAA, 32'sh0001_0000);
        wait_drained();

        // most negative register values: large gains, saturation on both sides
        load_quaternion(quat_t'(-32768), quat_t'(-32768), quat_t'(-32768), quat_t'(-32768));
        send_vector(1'b0, VEC_MAX, VEC_MAX, VEC_MAX);
        send_vector(1'b1, VEC_MIN, VEC_MIN, VEC_MIN);
        send_vector(1'b0, VEC_MAX, VEC_MIN, 32'sd0);
        send_vector(1'b1, 32'sd1, 32'sd1, 32'sd1);
        wait_drained();

        // most positive register values, not of unit length
        load_quaternion(quat_t'(32767), quat_t'(32767), quat_t'(32767), quat_t'(32767));
        send_vector(1'b0, VEC_MAX, 32'sd0, VEC_MIN);
        send_vector(1'b1, VEC_MAX, 32'sd0, VEC_MIN);
        wait_drained();

        // off-diagonal element of exactly half an lsb: rounding ties go upwards
        load_quaternion(quat_t'(0), quat_t'(8192), quat_t'(8192), quat_t'(0));
        send_vector(1'b0, 32'sd0, 32'sd1, 32'sd0);
        send_vector(1'b0, 32'sd0, -32'sd1, 32'sd0);
        send_vector(1'b1, 32'sd1, 32'sd0, 32'sd0);
        send_vector(1'b1, -32'sd1, 32'sd0, 32'sd0);
        wait_drained();

        // quarter turn about z, forward and inverse
        load_quaternion(quat_t'(11585), quat_t'(0), quat_t'(0), quat_t'(11585));
        send_vector(1'b0, 32'sh0001_0000, 32'sd0, 32'sd0);
        send_vector(1'b1, 32'sh0001_0000, 32'sd0, 32'sd0);
        send_vector(1'b0, 32'sd0, 32'sh0002_8000, -32'sh0000_4000);
        wait_drained();

        // random part: a fresh quaternion per phase, loaded only with the pipeline empty
        for (phase = 0; phase < RANDOM_PHASES; phase++) begin
            pick_quaternion(qw, qx, qy, qz);
            load_quaternion(qw, qx, qy, qz);
            // receiver holds off for a long while so the pipeline fills and s_ready drops
            if (phase == HOLD_PHASE)
                sink_hold_req = 1'b1;
            if (phase == RANDOM_PHASES - 1)
                quiet_tail = 1'b1;
            repeat (ITEMS_PER_PHASE)
                send_vector(1'($urandom_range(0, 1)), pick_component(), pick_component(),
                            pick_component());
            // sender pauses until every result of this phase has been transferred
            wait_drained();
        end

        // let any stray result show up before the verdict
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0 && pending == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// File: sim.f
design/qvr_pkg.sv
design/qvr_matrix.sv
design/qvr_front.sv
design/qvr_mac.sv
design/qvr_round.sv
design/quaternion_vector_rotator.sv
test/rotation_checker.sv
test/tb_quaternion_vector_rotator.sv
